// File: hdl/base64_stream_encoder_defines.svh
// ----------------------------------------------------------------------------
// base64 stream encoder assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define B64E_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// next-cycle implication
`define B64E_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`else

`define B64E_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define B64E_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the sextet-to-character map of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
    localparam logic [1:0] LAST_IDX = 2'd3;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } t_out_item;

    // one closed group, missing bytes already zero-filled
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  count;   // bytes in the group, 1..3
        logic        fin;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic       busy;
        logic [1:0] out_idx;  // position in its group of the character on the output
    } t_back_status;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] r;
        r = 8'h00;
        case (v) inside
            [6'd0 : 6'd25]:  r = 8'h41 + {2'b00, v};
            [6'd26 : 6'd51]: r = 8'h61 + {2'b00, v} - 8'd26;
            [6'd52 : 6'd61]: r = 8'h30 + {2'b00, v} - 8'd52;
            6'd62:           r = 8'h2B;
            6'd63:           r = 8'h2F;
            default:         r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, holds an open group of up to two, and pushes closed groups.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  b64e_pkg::t_in_item     i_in,
    input  b64e_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output b64e_pkg::t_group       o_group
);

    logic [7:0] r_held_first, n_held_first;
    logic [7:0] r_held_second, n_held_second;
    logic [1:0] r_held_count, n_held_count;
    logic [1:0] w_n;
    logic [1:0] w_n1;
    logic       w_accept;
    logic       w_close;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;
    // a count of three cannot arise; treat it as an empty group
    assign w_n      = (r_held_count == 2'd3) ? 2'd0 : r_held_count;
    assign w_n1     = w_n + 2'd1;
    assign w_close  = (w_n1 == 2'd3) || i_in.final_byte;
    assign o_push   = w_accept && w_close;

    always_comb begin
        o_group.count = w_n1;
        o_group.fin   = i_in.final_byte;
        case (w_n1)
            2'd1:    o_group.bytes = {i_in.data_byte, 16'h0000};
            2'd2:    o_group.bytes = {r_held_first, i_in.data_byte, 8'h00};
            2'd3:    o_group.bytes = {r_held_first, r_held_second, i_in.data_byte};
            default: o_group.bytes = 24'h000000;
        endcase
    end

    always_comb begin
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        n_held_count  = r_held_count;
        if (w_accept) begin
            if (w_n == 2'd0) begin
                n_held_first = i_in.data_byte;
            end else if (w_n == 2'd1) begin
                n_held_second = i_in.data_byte;
            end
            n_held_count = w_close ? 2'd0 : w_n1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_first  <= 8'h00;
            r_held_second <= 8'h00;
            r_held_count  <= 2'd0;
        end else begin
            r_held_first  <= n_held_first;
            r_held_second <= n_held_second;
            r_held_count  <= n_held_count;
        end
    end

endmodule

// File: hdl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry queue of closed groups between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  b64e_pkg::t_group        i_group,
    input  logic                    i_pop,
    output b64e_pkg::t_group        o_group,
    output b64e_pkg::t_queue_status o_status
);

    localparam int unsigned PTR_W = $clog2(b64e_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(b64e_pkg::QUEUE_DEPTH + 1);

    b64e_pkg::t_group r_mem [b64e_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == CNT_W'(b64e_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push  = i_push && !o_status.full;
    assign w_pop   = i_pop && !o_status.empty;
    assign o_group = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: hdl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Takes one group at a time and sends its four characters through an
// output register, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  b64e_pkg::t_queue_status i_q_status,
    input  b64e_pkg::t_group        i_group,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output b64e_pkg::t_out_item     o_out,
    output b64e_pkg::t_back_status  o_status
);

    b64e_pkg::t_group    r_group, n_group;
    logic                r_busy, n_busy;
    logic [1:0]          r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    b64e_pkg::t_out_item r_out, n_out;
    logic [1:0]          r_out_idx, n_out_idx;
    logic                w_can_load;
    logic [5:0]          w_sextet;
    b64e_pkg::t_out_item w_char;

    assign w_can_load = !r_out_valid || i_ready;
    assign o_pop = !i_q_status.empty
                   && (!r_busy || ((r_idx == b64e_pkg::LAST_IDX) && w_can_load));

    always_comb begin
        case (r_idx)
            2'd0:    w_sextet = r_group.bytes[23:18];
            2'd1:    w_sextet = r_group.bytes[17:12];
            2'd2:    w_sextet = r_group.bytes[11:6];
            2'd3:    w_sextet = r_group.bytes[5:0];
            default: w_sextet = 6'd0;
        endcase
        // positions whose index exceeds count are padding
        w_char.out_char = (r_idx <= r_group.count) ? b64e_pkg::sextet_char(w_sextet)
                                                   : b64e_pkg::PAD_CHAR;
        w_char.out_last = r_group.fin && (r_idx == b64e_pkg::LAST_IDX);
    end

    always_comb begin
        n_group     = r_group;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_idx   = r_out_idx;
        n_out_valid = r_out_valid && !i_ready;
        if (r_busy && w_can_load) begin
            n_out       = w_char;
            n_out_idx   = r_idx;
            n_out_valid = 1'b1;
            n_idx       = r_idx + 2'd1;
            if (r_idx == b64e_pkg::LAST_IDX) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_group = i_group;
            n_busy  = 1'b1;
            n_idx   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_group   <= n_group;
        r_idx     <= n_idx;
        r_out     <= n_out;
        r_out_idx <= n_out_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out            = r_out;
    assign o_status.busy    = r_busy;
    assign o_status.out_idx = r_out_idx;

endmodule

// File: hdl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Standard base64 encoder: bytes in, characters out, '=' padding on a
// partial final group.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      i_valid / o_ready    i_in  (data_byte, final_byte)
// out       output     o_valid / i_ready    o_out (out_char, out_last)
//
// a byte is taken every cycle while the two-group queue has room
// each closed group leaves as four characters on consecutive cycles unless
// the output stalls, so the single-character output sets the sustained rate
// first character of a group goes via the queue, group and output registers
// synchronous active-low reset empties the open group, queue and output
// an output stall fills the queue, then drops o_ready
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b64e_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output b64e_pkg::t_out_item o_out
);

    logic                    w_push;
    logic                    w_pop;
    b64e_pkg::t_group        w_push_group;
    b64e_pkg::t_group        w_head_group;
    b64e_pkg::t_queue_status w_q_status;
    b64e_pkg::t_back_status  w_back_status;

    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_group    (w_push_group)
    );

    b64e_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_group  (w_push_group),
        .i_pop    (w_pop),
        .o_group  (w_head_group),
        .o_status (w_q_status)
    );

    b64e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_group    (w_head_group),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .o_status   (w_back_status)
    );

    // no group is pushed into a full queue
    `B64E_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_push, !w_q_status.full)
    // the last flag rides only on the fourth character of a group
    `B64E_ASSERT_IMP(a_last_on_fourth, i_clk, i_rst_n, o_valid && o_out.out_last,
        w_back_status.out_idx == b64e_pkg::LAST_IDX)
    // padding can only fill the third or fourth position
    `B64E_ASSERT_IMP(a_pad_position, i_clk, i_rst_n,
        o_valid && (o_out.out_char == b64e_pkg::PAD_CHAR),
        (w_back_status.out_idx == 2'd2) || (w_back_status.out_idx == 2'd3))
    // a character taken mid-group is followed by the next one of the group
    `B64E_ASSERT_NXT(a_group_continues, i_clk, i_rst_n,
        o_valid && i_ready && (w_back_status.out_idx != b64e_pkg::LAST_IDX),
        o_valid && (w_back_status.out_idx == $past(w_back_status.out_idx) + 2'd1))

endmodule
